// File: hdl/grid_bucket_radius_search_top_macros.svh
// Assertion macros for the grid bucket search block.
// Used by the datapath; no other dependencies.
`ifndef GRID_BUCKET_RADIUS_SEARCH_TOP_MACROS_SVH
`define GRID_BUCKET_RADIUS_SEARCH_TOP_MACROS_SVH
`ifndef SYNTH
`define GBRS_AST_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define GBRS_AST_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define GBRS_AST_IMP(lbl, clk, rst, a, c)
`define GBRS_AST_NXT(lbl, clk, rst, a, c)
`endif
`endif

// File: hdl/gbrs_pkg.sv
// Package for the grid bucket search block: constants, codes and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package gbrs_pkg;
  localparam int GRID_COLS_DEF  = 64;
  localparam int GRID_ROWS_DEF  = 48;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int MAX_HITS_DEF   = 64;
  localparam int FI_W           = 10;
  localparam logic [15:0] SCALE_RESET = 16'd6554;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_SCALE_X  = 2'd2;
  localparam logic [1:0] REG_SCALE_Y  = 2'd3;

  typedef struct packed {
    logic accept;
    logic clear;
    logic mul_load;
    logic load_wr;
    logic mul_qx;
    logic mul_qy;
    logic range_y;
    logic rd;
    logic next_idx;
    logic next_cell;
    logic take;
    logic set_more;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic count_full;
    logic miss;
    logic scan_end;
    logic last_cell;
    logic match;
    logic hits_full;
    logic have_pend;
    logic out_free;
  } status_t;
endpackage

// File: hdl/gbrs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module gbrs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

// File: hdl/gbrs_ctrl.sv
// Sequencer for clear, load and window query requests.
// Depends on gbrs_pkg; drives the datapath by cmd_t, reads status_t.
`timescale 1ns / 1ps
module gbrs_ctrl import gbrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t st,
  output cmd_t    cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LMUL = 4'd1;
  localparam logic [3:0] S_LWR  = 4'd2;
  localparam logic [3:0] S_QMX  = 4'd3;
  localparam logic [3:0] S_QMY  = 4'd4;
  localparam logic [3:0] S_QRNG = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_EV   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          case (st.op)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_LOAD:  if (!st.count_full) state_next = S_LMUL;
            OP_QUERY: state_next = S_QMX;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LMUL: begin
        cmd.mul_load = 1'b1;
        state_next = S_LWR;
      end
      S_LWR: begin
        cmd.load_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_QMX: begin
        cmd.mul_qx = 1'b1;
        state_next = S_QMY;
      end
      S_QMY: begin
        cmd.mul_qy = 1'b1;
        state_next = S_QRNG;
      end
      S_QRNG: begin
        cmd.range_y = 1'b1;
        state_next = st.miss ? S_FIN : S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_end) begin
          if (st.last_cell) begin
            state_next = S_FIN;
          end else begin
            cmd.next_cell = 1'b1;
          end
        end else begin
          cmd.rd = 1'b1;
          state_next = S_EV;
        end
      end
      S_EV: begin
        if (!st.match) begin
          cmd.next_idx = 1'b1;
          state_next = S_SCAN;
        end else if (st.hits_full) begin
          cmd.set_more = 1'b1;
          state_next = S_FIN;
        end else if (!st.have_pend || st.out_free) begin
          cmd.take = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// File: hdl/gbrs_datapath.sv
// Datapath: point store, cell arithmetic, scan counters and result register.
// Depends on gbrs_pkg, gbrs_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "grid_bucket_radius_search_top_macros.svh"
module gbrs_datapath import gbrs_pkg::*; #(
  parameter int GRID_COLS  = GRID_COLS_DEF,
  parameter int GRID_ROWS  = GRID_ROWS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_HITS   = MAX_HITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_x,
  input  logic [15:0] in_y,
  input  logic [2:0]  in_level,
  input  logic [15:0] in_radius,
  input  logic [3:0]  in_min_level,
  input  logic [2:0]  in_max_level,
  input  logic [15:0] origin_x,
  input  logic [15:0] origin_y,
  input  logic [15:0] scale_x,
  input  logic [15:0] scale_y,
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [FI_W-1:0] out_index,
  output logic        out_found,
  output logic        out_last,
  output logic        out_trunc
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int HW = $clog2(MAX_HITS + 1);
  localparam int MW = 36 + CW + RW;
  localparam logic signed [16:0] NCOL = 17'(GRID_COLS);
  localparam logic signed [16:0] NROW = 17'(GRID_ROWS);
  localparam logic signed [35:0] HALF = 36'sd524288;
  localparam logic signed [35:0] ONEM = 36'sd1048575;

  logic [15:0] q_x, q_y, q_r;
  logic [2:0]  q_lvl, q_maxl;
  logic [3:0]  q_minl;
  logic [AW:0] count, idx;
  logic [HW-1:0] nhits;
  logic [AW-1:0] pend;
  logic have_pend, more;
  logic [CW-1:0] x0, x1, col;
  logic [RW-1:0] y1, row, y0;
  logic xmiss;
  logic signed [35:0] p0, p1;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q_x <= in_x;
      q_y <= in_y;
      q_r <= in_radius;
      q_lvl <= in_level;
      q_minl <= in_min_level;
      q_maxl <= in_max_level;
    end
  end

  // offsets and window edges, 18-bit signed
  logic signed [17:0] dx, dy, dxm, dxp, dym, dyp;
  assign dx  = 18'($signed({1'b0, q_x}) - $signed({1'b0, origin_x}));
  assign dy  = 18'($signed({1'b0, q_y}) - $signed({1'b0, origin_y}));
  assign dxm = dx - $signed({2'b0, q_r});
  assign dxp = dx + $signed({2'b0, q_r});
  assign dym = dy - $signed({2'b0, q_r});
  assign dyp = dy + $signed({2'b0, q_r});

  logic signed [17:0] a0, a1;
  logic [15:0] b0, b1;
  always_comb begin
    a0 = dx;
    a1 = dy;
    b0 = scale_x;
    b1 = scale_y;
    if (cmd.mul_qx) begin
      a0 = dxm;
      a1 = dxp;
      b1 = scale_x;
    end else if (cmd.mul_qy) begin
      a0 = dym;
      a1 = dyp;
      b0 = scale_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load || cmd.mul_qx || cmd.mul_qy) begin
      p0 <= 36'(a0) * 36'($signed({1'b0, b0}));
      p1 <= 36'(a1) * 36'($signed({1'b0, b1}));
    end
  end

  // floor of low edge, ceiling of high edge
  logic signed [15:0] lo16, hi16;
  assign lo16 = 16'(p0 >>> 20);
  assign hi16 = 16'((p1 + ONEM) >>> 20);

  logic ymiss;
  logic [RW-1:0] y0c, y1c;
  assign ymiss = (lo16 >= NROW) || (hi16 < 0);
  assign y0c = (lo16 < 0) ? '0 : lo16[RW-1:0];
  assign y1c = (hi16 > NROW - 17'sd1) ? RW'(GRID_ROWS - 1) : hi16[RW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_qy) begin
      xmiss <= (lo16 >= NCOL) || (hi16 < 0);
      x0 <= (lo16 < 0) ? '0 : lo16[CW-1:0];
      x1 <= (hi16 > NCOL - 17'sd1) ? CW'(GRID_COLS - 1) : hi16[CW-1:0];
    end
    if (cmd.range_y) begin
      y0 <= y0c;
      y1 <= y1c;
      row <= y0c;
      col <= x0;
    end else if (cmd.next_cell) begin
      if (row == y1) begin
        row <= y0;
        col <= col + CW'(1);
      end else begin
        row <= row + RW'(1);
      end
    end
  end

  // load binning: round half away from zero
  logic signed [35:0] cr, rr;
  logic col_ok, row_ok;
  assign cr = (p0 + HALF) >>> 20;
  assign rr = (p1 + HALF) >>> 20;
  assign col_ok = (p0 >= 0) ? (cr < 36'(NCOL)) : (p0 > -HALF);
  assign row_ok = (p1 >= 0) ? (rr < 36'(NROW)) : (p1 > -HALF);

  logic [MW-1:0] wdata, rdata;
  assign wdata = {col_ok && row_ok, rr[RW-1:0], cr[CW-1:0], q_lvl, q_y, q_x};

  gbrs_ram #(.W(MW), .D(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (cmd.load_wr),
    .re    (cmd.rd),
    .addr  (cmd.load_wr ? count[AW-1:0] : idx[AW-1:0]),
    .wdata (wdata),
    .rdata (rdata)
  );

  logic [15:0] px, py;
  logic [2:0] plvl;
  logic [CW-1:0] pcol;
  logic [RW-1:0] prow;
  logic ping;
  assign {ping, prow, pcol, plvl, py, px} = rdata;

  logic [16:0] adx, ady;
  logic lvl_ok;
  assign adx = (px >= q_x) ? 17'(px - q_x) : 17'(q_x - px);
  assign ady = (py >= q_y) ? 17'(py - q_y) : 17'(q_y - py);
  assign lvl_ok = q_minl[3] || ((plvl >= q_minl[2:0]) && (plvl <= q_maxl));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.load_wr) begin
      count <= count + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      nhits <= '0;
      have_pend <= 1'b0;
      more <= 1'b0;
    end else if (cmd.range_y) begin
      idx <= '0;
      nhits <= '0;
      have_pend <= 1'b0;
      more <= 1'b0;
    end else begin
      if (cmd.next_cell) idx <= '0;
      if (cmd.next_idx || cmd.take) idx <= idx + (AW+1)'(1);
      if (cmd.take) begin
        nhits <= nhits + HW'(1);
        have_pend <= 1'b1;
      end
      if (cmd.set_more) more <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) pend <= idx[AW-1:0];
  end

  logic push;
  assign push = (cmd.take && have_pend) || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_index <= have_pend ? FI_W'(pend) : '0;
      out_found <= have_pend;
      out_last  <= cmd.finish;
      out_trunc <= cmd.finish && more;
    end
  end

  assign st.op = in_op;
  assign st.count_full = (count >= (AW+1)'(MAX_POINTS));
  assign st.miss = xmiss || ymiss;
  assign st.scan_end = (idx == count);
  assign st.last_cell = (row == y1) && (col == x1);
  assign st.match = ping && (pcol == col) && (prow == row) && lvl_ok &&
                    (adx < {1'b0, q_r}) && (ady < {1'b0, q_r});
  assign st.hits_full = (nhits == HW'(MAX_HITS));
  assign st.have_pend = have_pend;
  assign st.out_free = !m_tvalid || m_tready;

  `GBRS_AST_IMP(a_count_cap, clk, rst, 1'b1, count <= (AW+1)'(MAX_POINTS))
  `GBRS_AST_IMP(a_hits_cap, clk, rst, 1'b1, nhits <= HW'(MAX_HITS))
  `GBRS_AST_IMP(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !push)
  `GBRS_AST_NXT(a_final_last, clk, rst, cmd.finish, m_tvalid && out_last)
endmodule

// File: hdl/grid_bucket_radius_search_top.sv
// Uniform-grid keypoint store with square-window search.
// Input requests on the s_ channel carry op in s_tuser: clear (op 0), load
// a keypoint (op 1) or window query (op 2). Results leave on the m_ channel;
// m_tlast marks the final result of a query, m_tuser gives found and
// truncated. Registers must be written over the APB port only while idle;
// the block does not enforce this. Clear acts directly in idle; a load
// computes the cell, then writes the point store; a load at capacity is
// dropped. A query computes the window, then for every clamped cell walks all
// stored points, one RAM read and one check per entry through the single RAM
// port. A window off the grid ends the query without a scan. Each hit leaves
// when the next one is found or at the end of the query; at most MAX_HITS
// results per query. Reset empties the store and restores register defaults.
// A stalled receiver holds the result register and the scan waits; a new
// request is taken while the last result of the previous query still waits.
// Depends on gbrs_pkg, gbrs_ctrl and gbrs_datapath.
`timescale 1ns / 1ps
module grid_bucket_radius_search_top import gbrs_pkg::*; #(
  parameter int GRID_COLS  = GRID_COLS_DEF,
  parameter int GRID_ROWS  = GRID_ROWS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_HITS   = MAX_HITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // coord_x[15:0], coord_y[31:16], level[34:32], radius[50:35],
  // min_level[54:51], max_level[57:55], zero pad
  input  logic [63:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // feature_index[9:0], zero pad
  output logic [15:0] m_tdata,
  // found[0], truncated[1]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] origin_x, origin_y, scale_x, scale_y;
  logic [1:0] ridx;
  cmd_t cmd;
  status_t st;
  logic [FI_W-1:0] out_index;
  logic out_found, out_trunc;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      scale_x <= SCALE_RESET;
      scale_y <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_ORIGIN_X: origin_x <= pwdata[15:0];
        REG_ORIGIN_Y: origin_y <= pwdata[15:0];
        REG_SCALE_X:  scale_x <= pwdata[15:0];
        REG_SCALE_Y:  scale_y <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ORIGIN_X: prdata = {16'b0, origin_x};
      REG_ORIGIN_Y: prdata = {16'b0, origin_y};
      REG_SCALE_X:  prdata = {16'b0, scale_x};
      REG_SCALE_Y:  prdata = {16'b0, scale_y};
      default:      prdata = '0;
    endcase
  end

  gbrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  gbrs_datapath #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .MAX_POINTS (MAX_POINTS),
    .MAX_HITS   (MAX_HITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_op        (s_tuser),
    .in_x         (s_tdata[15:0]),
    .in_y         (s_tdata[31:16]),
    .in_level     (s_tdata[34:32]),
    .in_radius    (s_tdata[50:35]),
    .in_min_level (s_tdata[54:51]),
    .in_max_level (s_tdata[57:55]),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .scale_x      (scale_x),
    .scale_y      (scale_y),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .out_index    (out_index),
    .out_found    (out_found),
    .out_last     (m_tlast),
    .out_trunc    (out_trunc)
  );

  assign m_tdata = {(16 - FI_W)'(0), out_index};
  assign m_tuser = {out_trunc, out_found};
endmodule

// File: sim/tb_top.sv
// Testbench for grid_bucket_radius_search_top: loads, clears and window queries
// checked against a behavioural keypoint-grid model in a scoreboard class.
// Depends on gbrs_pkg and the block's RTL.
`timescale 1ns / 1ps

typedef struct {
  logic [9:0] idx;
  bit         found;
  bit         last;
  bit         trunc;
} grid_hit_t;

class grid_search_sb;
  longint org_x = 0, org_y = 0, scl_x = 6554, scl_y = 6554;
  longint pt_x[1024], pt_y[1024], pt_cell[1024];
  int     pt_lvl[1024];
  bit     pt_in[1024];
  int     pt_count = 0;
  grid_hit_t hits_q[$];
  int     errors = 0;

  function longint fl20(longint v);
    return v >>> 20;
  endfunction

  function longint cl20(longint v);
    return -((-v) >>> 20);
  endfunction

  function longint rnd20(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 19)) >>> 20;
    return -((-v + (64'sd1 <<< 19)) >>> 20);
  endfunction

  function bit axis_span(longint q, longint org, longint r, longint s, longint cells,
                         output longint lo, output longint hi);
    longint d;
    d  = q - org;
    lo = fl20((d - r) * s);
    hi = cl20((d + r) * s);
    if (lo < 0) lo = 0;
    if (hi > cells - 1) hi = cells - 1;
    return (lo < cells) && (hi >= 0);
  endfunction

  function void note_request(logic [1:0] op, logic [15:0] cx, logic [15:0] cy,
                             logic [2:0] lvl, logic [15:0] rad,
                             logic signed [3:0] minl, logic [2:0] maxl);
    longint col, row, x0, x1, y0, y1, dx, dy;
    int n;
    bit more, inside_grid;
    grid_hit_t h;
    n = 0;
    more = 0;
    if (op == gbrs_pkg::OP_CLEAR) begin
      pt_count = 0;
    end else if (op == gbrs_pkg::OP_LOAD) begin
      if (pt_count < 1024) begin
        col = rnd20((longint'(cx) - org_x) * scl_x);
        row = rnd20((longint'(cy) - org_y) * scl_y);
        pt_x[pt_count]   = cx;
        pt_y[pt_count]   = cy;
        pt_lvl[pt_count] = lvl;
        pt_in[pt_count]  = col >= 0 && col < 64 && row >= 0 && row < 48;
        pt_cell[pt_count] = pt_in[pt_count] ? col * 48 + row : 0;
        pt_count++;
      end
    end else if (op == gbrs_pkg::OP_QUERY) begin
      inside_grid = axis_span(cx, org_x, rad, scl_x, 64, x0, x1);
      if (inside_grid) inside_grid = axis_span(cy, org_y, rad, scl_y, 48, y0, y1);
      if (inside_grid) begin
        for (longint c = x0; c <= x1 && !more; c++) begin
          for (longint r = y0; r <= y1 && !more; r++) begin
            for (int i = 0; i < pt_count && !more; i++) begin
              if (!pt_in[i] || pt_cell[i] != c * 48 + r) continue;
              if (minl >= 0 && (pt_lvl[i] < minl || pt_lvl[i] > maxl)) continue;
              dx = pt_x[i] - longint'(cx);
              dy = pt_y[i] - longint'(cy);
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              if (!(dx < rad && dy < rad)) continue;
              if (n >= 64) begin
                more = 1;
              end else begin
                h.idx = i[9:0];
                h.found = 1;
                h.last = 0;
                h.trunc = 0;
                hits_q.insert(hits_q.size(), h);
                n++;
              end
            end
          end
        end
      end
      if (n == 0) begin
        h.idx = '0;
        h.found = 0;
        h.last = 1;
        h.trunc = 0;
        hits_q.insert(hits_q.size(), h);
      end else begin
        hits_q[hits_q.size() - 1].last  = 1;
        hits_q[hits_q.size() - 1].trunc = more;
      end
    end
  endfunction

  function void check_result(logic [9:0] idx, logic found, logic last, logic trunc);
    grid_hit_t w;
    if (hits_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result idx=%0d found=%0b last=%0b trunc=%0b",
                 idx, found, last, trunc);
      return;
    end
    w = hits_q.pop_front();
    if (idx !== w.idx || found !== w.found || last !== w.last || trunc !== w.trunc) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp idx=%0d found=%0b last=%0b trunc=%0b, got %0d %0b %0b %0b",
                 w.idx, w.found, w.last, w.trunc, idx, found, last, trunc);
    end
  endfunction
endclass

module tb_top;
  import gbrs_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int LIMIT = 1_500_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_search_sb sb = new();
  int burst_left = 4;
  int cycles = 0;
  int stall_mode = 0;

  grid_bucket_radius_search_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: checks each accepted result; the stall mode is picked at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[9:0], m_tuser[0], m_tlast, m_tuser[1]);
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= cycles[1];
    endcase
  end

  function automatic logic [15:0] sat16(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  task automatic send_req(input logic [1:0] op, input logic [15:0] cx, input logic [15:0] cy,
                          input logic [2:0] lvl, input logic [15:0] rad,
                          input logic signed [3:0] minl, input logic [2:0] maxl);
    s_tuser  <= op;
    s_tdata  <= {6'd0, maxl, minl, rad, lvl, cy, cx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, cx, cy, lvl, rad, minl, maxl);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.hits_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ORIGIN_X: sb.org_x = val;
      REG_ORIGIN_Y: sb.org_y = val;
      REG_SCALE_X:  sb.scl_x = val;
      default:      sb.scl_y = val;
    endcase
  endtask

  task automatic set_grid(input logic [15:0] ox, input logic [15:0] oy,
                          input logic [15:0] sx, input logic [15:0] sy);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
  endtask

  task automatic random_phase(input int n);
    longint span_x, span_y, rmax, cx, cy;
    int pick, k;
    logic signed [3:0] minl;
    span_x = (sb.scl_x == 0) ? 65535 : (64'd64 << 20) / sb.scl_x;
    span_y = (sb.scl_y == 0) ? 65535 : (64'd48 << 20) / sb.scl_y;
    rmax = 65535;
    if (sb.scl_x != 0 && (64'd2 << 20) / sb.scl_x < rmax) rmax = (64'd2 << 20) / sb.scl_x;
    if (sb.scl_y != 0 && (64'd2 << 20) / sb.scl_y < rmax) rmax = (64'd2 << 20) / sb.scl_y;
    if (rmax < 1) rmax = 1;
    send_req(OP_CLEAR, 16'd0, 16'd0, 3'd0, 16'd0, 4'sd0, 3'd0);
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (sb.pt_count > 40) pick = 99;
      minl = ($urandom_range(0, 2) == 0) ? -4'sd1 : 4'($urandom_range(0, 7));
      if (pick < 3) begin
        send_req(OP_SPARE, 16'($urandom), 16'($urandom), 3'($urandom), 16'($urandom),
                 4'($urandom), 3'($urandom));
      end else if (pick < 50) begin
        if ($urandom_range(0, 9) == 0) begin
          cx = $urandom_range(0, 65535);
          cy = $urandom_range(0, 65535);
        end else begin
          cx = sb.org_x + $urandom_range(0, span_x);
          cy = sb.org_y + $urandom_range(0, span_y);
        end
        send_req(OP_LOAD, sat16(cx), sat16(cy), 3'($urandom), 16'($urandom),
                 4'($urandom), 3'($urandom));
      end else if (pick < 95) begin
        if (sb.pt_count > 0 && $urandom_range(0, 9) < 7) begin
          k  = $urandom_range(0, sb.pt_count - 1);
          cx = sb.pt_x[k] + longint'($urandom_range(0, rmax)) - rmax / 2;
          cy = sb.pt_y[k] + longint'($urandom_range(0, rmax)) - rmax / 2;
        end else begin
          cx = sb.org_x + $urandom_range(0, span_x);
          cy = sb.org_y + $urandom_range(0, span_y);
        end
        send_req(OP_QUERY, sat16(cx), sat16(cy), 3'($urandom),
                 ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, rmax)),
                 minl, 3'($urandom));
      end else begin
        send_req(OP_CLEAR, 16'($urandom), 16'($urandom), 3'($urandom), 16'($urandom),
                 4'($urandom), 3'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    send_req(OP_QUERY, 16'd100, 16'd100, 3'd0, 16'd200, -4'sd1, 3'd0);
    send_req(OP_LOAD, 16'd0, 16'd0, 3'd0, 16'd0, 4'sd0, 3'd0);
    send_req(OP_LOAD, 16'd160, 16'd160, 3'd7, 16'hFFFF, -4'sd1, 3'd7);
    send_req(OP_LOAD, 16'hFFFF, 16'hFFFF, 3'd3, 16'd0, 4'sd0, 3'd0);
    send_req(OP_LOAD, 16'd80, 16'd80, 3'd5, 16'd0, 4'sd0, 3'd0);
    send_req(OP_QUERY, 16'd100, 16'd100, 3'd0, 16'd200, -4'sd1, 3'd0);
    send_req(OP_QUERY, 16'd100, 16'd100, 3'd7, 16'd200, 4'sd2, 3'd6);
    send_req(OP_QUERY, 16'd100, 16'd100, 3'd0, 16'd200, 4'sd6, 3'd2);
    send_req(OP_QUERY, 16'd80, 16'd80, 3'd0, 16'd0, -4'sd1, 3'd7);
    send_req(OP_QUERY, 16'hFFFF, 16'hFFFF, 3'd0, 16'hFFFF, -4'sd1, 3'd7);
    send_req(OP_QUERY, 16'hFFFF, 16'hFFFF, 3'd0, 16'd16, 4'sd7, 3'd7);
    send_req(OP_SPARE, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, -4'sd1, 3'd7);
    send_req(OP_QUERY, 16'd0, 16'd0, 3'd0, 16'd1, 4'sd0, 3'd0);
    send_req(OP_CLEAR, 16'd0, 16'd0, 3'd0, 16'd0, 4'sd0, 3'd0);
    send_req(OP_QUERY, 16'd100, 16'd100, 3'd0, 16'd200, -4'sd1, 3'd0);
    // more hits than the output limit in one cell
    for (int i = 0; i < 70; i++)
      send_req(OP_LOAD, 16'(500 + i % 3), 16'd500, 3'(i), 16'd0, 4'sd0, 3'd0);
    send_req(OP_QUERY, 16'd501, 16'd500, 3'd0, 16'd40, -4'sd1, 3'd0);
    send_req(OP_QUERY, 16'd501, 16'd500, 3'd0, 16'd40, 4'sd3, 3'd4);
    send_req(OP_CLEAR, 16'd0, 16'd0, 3'd0, 16'd0, 4'sd0, 3'd0);
    drain();

    set_grid(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    random_phase(20);
    set_grid(16'hFFFF, 16'hFFFF, 16'd6554, 16'd6554);
    random_phase(10);
    set_grid(16'($urandom_range(0, 20000)), 16'($urandom_range(0, 20000)), 16'd0,
             16'($urandom_range(2000, 65535)));
    random_phase(20);
    set_grid(16'($urandom_range(0, 30000)), 16'($urandom_range(0, 30000)),
             16'($urandom_range(2000, 65535)), 16'($urandom_range(2000, 65535)));
    random_phase(20);
    set_grid(16'($urandom_range(0, 30000)), 16'($urandom_range(0, 30000)),
             16'($urandom_range(2000, 65535)), 16'd0);
    random_phase(20);

    if (sb.errors == 0 && sb.hits_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
